// ===== rtl/core/s2u_pkg.sv =====
`default_nettype none

package s2u_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_LEAD = 2'd1,
        CMD_CODE = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  data_byte;
        logic [7:0]  table_index;
        logic [15:0] single_code;
        logic [7:0]  range_begin;
        logic [7:0]  range_end;
        logic [13:0] lut_base;
        logic [13:0] lut_address;
        logic [15:0] lut_code;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       unmapped_error;
    } t_out_item;

    // message byte classes
    localparam logic [7:0] BYTE_RAW_PAIR = 8'h10;
    localparam logic [7:0] BYTE_ESCAPE   = 8'h80;
    localparam logic [7:0] ESC_RAW_MAX   = 8'h11;
    localparam logic [7:0] CTRL_MAX      = 8'h1C;

    // UTF-8 encoding
    localparam logic [15:0] CP_ONE_MAX = 16'h007F;
    localparam logic [15:0] CP_TWO_MAX = 16'h07FF;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [5:0]  UTF8_MASK  = 6'h3F;

endpackage

`default_nettype wire

// ===== rtl/core/s2u_stream_if.sv =====
`default_nettype none

interface s2u_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sjis_to_utf8_stream_transcoder.sv =====
`default_nettype none

// Channel   Dir  Payload     Handshake
// i_in      in   t_in_item   valid/ready, item taken when both high
// o_out     out  t_out_item  valid/ready, item taken when both high
//
// A message byte yields zero to three output items, one per cycle on o_out
// while o_out is ready, so the output port sets the rate; the lead byte of
// a pair, a table load and a NOP item yield none. The first output of an
// item passes through the decode, result and output registers in turn.
// Reset clears the mode, raw count, pending lead and stage valid flags; the
// lead table and the code memory hold garbage until loaded, no clearing pass.
// A stall on o_out backs up through the result and decode registers to i_in.
module sjis_to_utf8_stream_transcoder #(
    parameter int CODE_MEMORY_DEPTH = 16384
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    s2u_stream_if.sink    i_in,
    s2u_stream_if.source  o_out
);
    import s2u_pkg::*;

    localparam int AW    = $clog2(CODE_MEMORY_DEPTH);
    localparam int RECIP = 65536 / CODE_MEMORY_DEPTH;
    localparam int QW    = $clog2(RECIP + 1);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESCAPE = 3'b010,
        MODE_TRAIL  = 3'b100
    } t_mode;

    typedef enum logic [1:0] {
        K_RAW  = 2'd0,
        K_CODE = 2'd1,
        K_MEM  = 2'd2,
        K_ERR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [15:0]   single;
        logic [7:0]    lo;
        logic [7:0]    hi;
        logic [13:0]   base;
        logic [QW-1:0] qbase;
    } t_lead;

    // estimated quotient of x / depth, low by at most one
    function automatic logic [QW-1:0] f_quot(input logic [13:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'(RECIP);
        return QW'(p >> 16);
    endfunction

    function automatic logic [AW-1:0] f_reduce(input logic [13:0] x,
                                               input logic [QW-1:0] q);
        logic [31:0] r;
        r = 32'(x) - 32'(q) * 32'(CODE_MEMORY_DEPTH);
        if (r >= 32'(CODE_MEMORY_DEPTH)) begin
            r = r - 32'(CODE_MEMORY_DEPTH);
        end
        return AW'(r);
    endfunction

    function automatic logic [AW-1:0] f_wrap_add(input logic [AW-1:0] a,
                                                 input logic [7:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + (AW+1)'(b);
        if (s >= (AW+1)'(CODE_MEMORY_DEPTH)) begin
            s = s - (AW+1)'(CODE_MEMORY_DEPTH);
        end
        return AW'(s);
    endfunction

    // tables
    t_lead       r_lead_mem [256];
    logic [15:0] r_code_mem [CODE_MEMORY_DEPTH];
    t_lead       r_lead_rd;
    logic [15:0] r_cm_rd;

    // decode stage
    logic          r1_valid;
    t_in_item      r1_item;
    logic [QW-1:0] r1_qbase;
    logic [QW-1:0] r1_qaddr;

    // parse state
    t_mode         r_mode, n_mode;
    logic [1:0]    r_raw, n_raw;
    logic [7:0]    r_pend_lead;
    logic [7:0]    r_pend_lo;
    logic [7:0]    r_pend_hi;
    logic [AW-1:0] r_pend_bm;

    // result stage
    logic          r2_valid;
    t_kind         r2_kind;
    logic [7:0]    r2_byte;
    logic [15:0]   r2_code;
    logic [1:0]    r2_idx;

    // output register
    logic          r_o_valid;
    t_out_item     r_o_item;

    logic          in_fire;
    logic          s1_adv;
    logic          s2_take;
    logic          o_load;

    logic          d_res;
    t_kind         d_kind;
    logic          d_latch;
    logic          d_pend_upd;
    logic          d_cm_rd;
    logic          d_cm_wr;
    logic          d_normal;
    logic [AW-1:0] d_rd_addr;
    logic [AW-1:0] d_wr_addr;

    logic [15:0]   e_cp;
    logic [7:0]    e_byte;
    logic          e_last;
    logic          e_err;

    assign in_fire    = i_in.valid && i_in.ready;
    assign s2_take    = !r2_valid || (o_load && e_last);
    assign s1_adv     = r1_valid && (!d_res || s2_take);
    assign i_in.ready = !r1_valid || s1_adv;
    assign o_load     = r2_valid && (!r_o_valid || o_out.ready);

    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o_item;

    // lead table: written on accepting a lead item, read for every accepted item
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (i_in.data.command == CMD_LEAD) begin
                r_lead_mem[i_in.data.table_index] <= '{
                    single: i_in.data.single_code,
                    lo:     i_in.data.range_begin,
                    hi:     i_in.data.range_end,
                    base:   i_in.data.lut_base,
                    qbase:  f_quot(i_in.data.lut_base)
                };
            end
            r_lead_rd <= r_lead_mem[i_in.data.data_byte];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r1_item  <= i_in.data;
            r1_qbase <= f_quot(i_in.data.lut_base);
            r1_qaddr <= f_quot(i_in.data.lut_address);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r1_valid <= i_in.valid;
        end
    end

    // decode one item against the parse state
    always_comb begin
        n_mode     = r_mode;
        n_raw      = r_raw;
        d_res      = 1'b0;
        d_kind     = K_RAW;
        d_latch    = 1'b0;
        d_pend_upd = 1'b0;
        d_cm_rd    = 1'b0;
        d_cm_wr    = 1'b0;
        d_normal   = 1'b0;
        d_rd_addr  = f_wrap_add(r_pend_bm, r1_item.data_byte);
        d_wr_addr  = f_reduce(r1_item.lut_address, r1_qaddr);
        unique case (r1_item.command)
            CMD_BYTE: begin
                if (r_raw != 2'd0) begin
                    n_raw = r_raw - 2'd1;
                    d_res = 1'b1;
                end else if (r_mode == MODE_TRAIL) begin
                    n_mode = MODE_NORMAL;
                    d_res  = 1'b1;
                    if (r1_item.data_byte < r_pend_lo || r1_item.data_byte > r_pend_hi) begin
                        d_kind = K_ERR;
                    end else begin
                        d_kind  = K_MEM;
                        d_cm_rd = 1'b1;
                    end
                end else begin
                    d_normal = 1'b1;
                    if (r_mode == MODE_ESCAPE) begin
                        n_mode = MODE_NORMAL;
                        if (r1_item.data_byte <= ESC_RAW_MAX) begin
                            d_res    = 1'b1;
                            d_normal = 1'b0;
                        end
                    end
                end
                if (d_normal) begin
                    if (r1_item.data_byte == BYTE_RAW_PAIR) begin
                        n_raw = 2'd2;
                        d_res = 1'b1;
                    end else if (r1_item.data_byte == BYTE_ESCAPE) begin
                        n_mode = MODE_ESCAPE;
                        d_res  = 1'b1;
                    end else if (r1_item.data_byte <= CTRL_MAX) begin
                        d_res = 1'b1;
                    end else if (r_lead_rd.single != 16'd0) begin
                        d_res  = 1'b1;
                        d_kind = K_CODE;
                    end else begin
                        n_mode  = MODE_TRAIL;
                        d_latch = 1'b1;
                    end
                end
            end
            CMD_LEAD: begin
                // keep the waiting lead's copy in step with a rewrite of its entry
                d_pend_upd = (r1_item.table_index == r_pend_lead);
            end
            CMD_CODE: begin
                d_cm_wr = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_raw       <= 2'd0;
            r_pend_lead <= 8'd0;
        end else if (s1_adv) begin
            r_mode <= n_mode;
            r_raw  <= n_raw;
            if (d_latch) begin
                r_pend_lead <= r1_item.data_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            if (d_latch) begin
                r_pend_lo <= r_lead_rd.lo;
                r_pend_hi <= r_lead_rd.hi;
                r_pend_bm <= f_reduce(r_lead_rd.base, r_lead_rd.qbase);
            end else if (d_pend_upd) begin
                r_pend_lo <= r1_item.range_begin;
                r_pend_hi <= r1_item.range_end;
                r_pend_bm <= f_reduce(r1_item.lut_base, r1_qbase);
            end
        end
    end

    // code memory: reads and writes both in decode order
    always_ff @(posedge i_clk) begin
        if (s1_adv && d_cm_wr) begin
            r_code_mem[d_wr_addr] <= r1_item.lut_code;
        end
        if (s1_adv && d_cm_rd) begin
            r_cm_rd <= r_code_mem[d_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && d_res) begin
            r2_kind <= d_kind;
            r2_byte <= r1_item.data_byte;
            r2_code <= r_lead_rd.single;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r2_idx   <= 2'd0;
        end else if (s1_adv && d_res) begin
            r2_valid <= 1'b1;
            r2_idx   <= 2'd0;
        end else if (o_load) begin
            if (e_last) begin
                r2_valid <= 1'b0;
                r2_idx   <= 2'd0;
            end else begin
                r2_idx <= r2_idx + 2'd1;
            end
        end
    end

    // pick the output byte for the current position in the run
    always_comb begin
        e_cp   = (r2_kind == K_MEM) ? r_cm_rd : r2_code;
        e_byte = r2_byte;
        e_last = 1'b1;
        e_err  = 1'b0;
        unique case (r2_kind)
            K_RAW: begin
            end
            K_ERR: begin
                e_byte = 8'd0;
                e_err  = 1'b1;
            end
            default: begin
                if (e_cp == 16'd0) begin
                    // unmapped pair
                    e_byte = 8'd0;
                    e_err  = 1'b1;
                end else if (e_cp <= CP_ONE_MAX) begin
                    e_byte = e_cp[7:0];
                end else if (e_cp <= CP_TWO_MAX) begin
                    e_last = (r2_idx == 2'd1);
                    e_byte = (r2_idx == 2'd0) ? (UTF8_LEAD2 | {3'b000, e_cp[10:6]})
                                              : (UTF8_CONT | {2'b00, e_cp[5:0] & UTF8_MASK});
                end else begin
                    e_last = (r2_idx == 2'd2);
                    case (r2_idx)
                        2'd0:    e_byte = UTF8_LEAD3 | {4'b0000, e_cp[15:12]};
                        2'd1:    e_byte = UTF8_CONT | {2'b00, e_cp[11:6] & UTF8_MASK};
                        default: e_byte = UTF8_CONT | {2'b00, e_cp[5:0] & UTF8_MASK};
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_item <= '{out_byte: e_byte, last_of_run: e_last, unmapped_error: e_err};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire
